// File: hw/rtl/forward_reverse_power_swr_meter_macros.svh
// Assertion macros for the forward/reverse power and SWR meter.
// No dependencies; included by the files that carry assertions.
`ifndef FORWARD_REVERSE_POWER_SWR_METER_MACROS_SVH
`define FORWARD_REVERSE_POWER_SWR_METER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property checked on the rising clock edge, off while in reset.
`define FRSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication checked on the rising clock edge, off while in reset.
`define FRSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define FRSM_ASSERT(lbl, prop, msg)
`define FRSM_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/frsm_pkg.sv
// Widths, constants and pipeline depths of the power and SWR meter.
// No dependencies.
package frsm_pkg;

  localparam int unsigned MV_W    = 12;
  localparam int unsigned SQ_W    = 2 * MV_W;
  localparam int unsigned PWR_W   = 18;
  localparam int unsigned SWR_W   = 15;
  localparam int unsigned SWR_FRAC = 8;
  localparam int unsigned NUM_W   = MV_W + 1 + SWR_FRAC;

  localparam logic [PWR_W-1:0] PWR_MAX = {PWR_W{1'b1}};
  localparam logic [SWR_W-1:0] SWR_SAT = SWR_W'(25344);
  localparam logic [MV_W-1:0]  SWR_MIN_FWD = MV_W'(30);

  // clamp of the reflection ratio at 49/50
  localparam int unsigned RHO_NUM = 49;
  localparam int unsigned RHO_DEN = 50;
  localparam int unsigned RHO_W   = MV_W + 6;

  // divide by 90 through a reciprocal and one correction
  localparam int unsigned PWR_DIV   = 90;
  localparam int unsigned RECIP_SH  = 30;
  localparam int unsigned RECIP_W   = 24;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / PWR_DIV);

  // pipeline depths
  localparam int unsigned PWR_LAT = 3;
  localparam int unsigned DIV_BPS = 3;
  localparam int unsigned DIV_LAT = (SWR_W + DIV_BPS - 1) / DIV_BPS;
  localparam int unsigned PWR_DLY = DIV_LAT - PWR_LAT;
  localparam int unsigned NSTG    = DIV_LAT + 2;

endpackage

// File: hw/rtl/frsm_if.sv
// Request and result channel interfaces of the meter.
// Depends on frsm_pkg.
interface frsm_in_if;
  import frsm_pkg::*;
  logic            valid;
  logic            ready;
  logic            tx_on;
  logic [MV_W-1:0] fwd_mv;
  logic [MV_W-1:0] rev_mv;

  modport source (output valid, tx_on, fwd_mv, rev_mv, input ready);
  modport sink   (input valid, tx_on, fwd_mv, rev_mv, output ready);
endinterface

interface frsm_out_if;
  import frsm_pkg::*;
  logic             valid;
  logic             ready;
  logic             active;
  logic [PWR_W-1:0] fwd_power_mw;
  logic [PWR_W-1:0] rev_power_mw;
  logic [SWR_W-1:0] swr_q8;
  logic             swr_valid;

  modport source (output valid, active, fwd_power_mw, rev_power_mw, swr_q8, swr_valid,
                  input ready);
  modport sink   (input valid, active, fwd_power_mw, rev_power_mw, swr_q8, swr_valid,
                  output ready);
endinterface

// File: hw/rtl/frsm_pwr.sv
// Three-stage pipeline computing floor(mv*mv/90), saturated to the power width.
// Depends on frsm_pkg.
module frsm_pwr (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [frsm_pkg::MV_W-1:0]  mv_i,
  output logic [frsm_pkg::PWR_W-1:0] pwr_o
);
  import frsm_pkg::*;

  localparam int unsigned PROD_W = SQ_W + RECIP_W;
  localparam int unsigned QE_W   = SQ_W + 1 - 6;

  logic [SQ_W-1:0]  sq_q, sq2_q;
  logic [QE_W-1:0]  qe_q;
  logic [PROD_W-1:0] prod;
  logic [SQ_W:0]    back, rem;
  logic [QE_W:0]    quo;
  logic [PWR_W-1:0] pwr_d, pwr_q;

  // estimate is floor or floor - 1; one compare fixes it
  assign prod = PROD_W'(sq_q) * PROD_W'(RECIP);
  assign back = (SQ_W + 1)'(qe_q) * (SQ_W + 1)'(PWR_DIV);
  assign rem  = {1'b0, sq2_q} - back;

  always_comb begin
    quo = {1'b0, qe_q};
    if (rem >= (SQ_W + 1)'(PWR_DIV)) begin
      quo = quo + 1'b1;
    end
    if (quo > (QE_W + 1)'(PWR_MAX)) begin
      pwr_d = PWR_MAX;
    end else begin
      pwr_d = PWR_W'(quo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= SQ_W'(mv_i) * SQ_W'(mv_i);
      qe_q  <= QE_W'(prod >> RECIP_SH);
      sq2_q <= sq_q;
      pwr_q <= pwr_d;
    end
  end

  assign pwr_o = pwr_q;

endmodule

// File: hw/rtl/frsm_div.sv
// Pipelined restoring divider: DIV_BPS quotient bits per stage, DIV_LAT stages.
// Depends on frsm_pkg. Quotient must fit SWR_W bits for the result to hold.
module frsm_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [frsm_pkg::NUM_W-1:0] num_i,
  input  logic [frsm_pkg::MV_W-1:0]  den_i,
  output logic [frsm_pkg::SWR_W-1:0] quo_o
);
  import frsm_pkg::*;

  localparam int unsigned CMP_W = MV_W + SWR_W;
  localparam int unsigned BIT_W = $clog2(SWR_W);

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [MV_W-1:0]  den;
    logic [SWR_W-1:0] quo;
  } dstg_t;

  function automatic dstg_t div_step(dstg_t x, logic [BIT_W-1:0] bitn);
    logic [CMP_W-1:0] dsh;
    dstg_t y;
    y   = x;
    dsh = CMP_W'(x.den) << bitn;
    if (CMP_W'(x.rem) >= dsh) begin
      y.rem       = x.rem - NUM_W'(dsh);
      y.quo[bitn] = 1'b1;
    end
    return y;
  endfunction

  dstg_t src [DIV_LAT];
  dstg_t stg_d [DIV_LAT];
  dstg_t stg_q [DIV_LAT];

  assign src[0] = '{rem: num_i, den: den_i, quo: '0};
  for (genvar g = 1; g < DIV_LAT; g++) begin : g_src
    assign src[g] = stg_q[g-1];
  end

  always_comb begin
    for (int s = 0; s < DIV_LAT; s++) begin
      stg_d[s] = src[s];
      for (int j = 0; j < DIV_BPS; j++) begin
        if (s * DIV_BPS + j < SWR_W) begin
          stg_d[s] = div_step(stg_d[s], BIT_W'(SWR_W - 1 - (s * DIV_BPS + j)));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_LAT; s++) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  assign quo_o = stg_q[DIV_LAT-1].quo;

endmodule

// File: hw/rtl/forward_reverse_power_swr_meter.sv
// Forward/reverse power and SWR meter, top level.
// One request per cycle while the result side is not stalled; a stall holds the whole pipeline.
// The depth is set by 7 register stages: the 5-stage divider (3 quotient bits per
// stage) plus an input stage and an output register; power runs in a 3-stage unit and a delay line.
// Reset (rst_ni low, asynchronous) empties the pipeline; payload is not reset.
// Depends on frsm_pkg, frsm_if, frsm_pwr, frsm_div and the macros header.
`include "forward_reverse_power_swr_meter_macros.svh"

module forward_reverse_power_swr_meter (
  input  logic       clk_i,
  input  logic       rst_ni,
  frsm_in_if.sink    in_i,
  frsm_out_if.source out_o
);
  import frsm_pkg::*;

  typedef struct packed {
    logic tx;
    logic ok;
    logic sat;
  } side_t;

  logic                en;
  logic [NSTG-1:0]     vld_q;

  // input stage
  side_t               side_d;
  side_t               side_q [DIV_LAT+1];
  logic [MV_W-1:0]     fwd_q, rev_q;
  logic [NUM_W-1:0]    num_q;
  logic [MV_W-1:0]     den_q;

  logic [PWR_W-1:0]    fwdp, revp;
  logic [PWR_W-1:0]    fwdp_q [PWR_DLY];
  logic [PWR_W-1:0]    revp_q [PWR_DLY];
  logic [SWR_W-1:0]    quo;
  side_t               side_l;

  logic                act_q, swrv_q;
  logic [PWR_W-1:0]    fwdo_q, revo_q;
  logic [SWR_W-1:0]    swr_d, swr_q;

  assign en       = !vld_q[NSTG-1] || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    side_d.tx  = in_i.tx_on;
    side_d.ok  = (in_i.fwd_mv > SWR_MIN_FWD) && (in_i.rev_mv < in_i.fwd_mv);
    side_d.sat = (RHO_W'(in_i.rev_mv) * RHO_W'(RHO_DEN))
               > (RHO_W'(in_i.fwd_mv) * RHO_W'(RHO_NUM));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      fwd_q     <= in_i.fwd_mv;
      rev_q     <= in_i.rev_mv;
      num_q     <= (NUM_W'(in_i.fwd_mv) + NUM_W'(in_i.rev_mv)) << SWR_FRAC;
      den_q     <= in_i.fwd_mv - in_i.rev_mv;
      for (int k = 1; k <= DIV_LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
      fwdp_q[0] <= fwdp;
      revp_q[0] <= revp;
      for (int k = 1; k < PWR_DLY; k++) begin
        fwdp_q[k] <= fwdp_q[k-1];
        revp_q[k] <= revp_q[k-1];
      end
    end
  end

  frsm_pwr u_pwr_fwd (
    .clk_i (clk_i),
    .en_i  (en),
    .mv_i  (fwd_q),
    .pwr_o (fwdp)
  );

  frsm_pwr u_pwr_rev (
    .clk_i (clk_i),
    .en_i  (en),
    .mv_i  (rev_q),
    .pwr_o (revp)
  );

  frsm_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_q),
    .den_i (den_q),
    .quo_o (quo)
  );

  assign side_l = side_q[DIV_LAT];

  // near-total reflection clamps at 99.0
  always_comb begin
    swr_d = '0;
    if (side_l.tx && side_l.ok) begin
      if (side_l.sat || quo > SWR_SAT) begin
        swr_d = SWR_SAT;
      end else begin
        swr_d = quo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      act_q  <= side_l.tx;
      swrv_q <= side_l.tx && side_l.ok;
      swr_q  <= swr_d;
      fwdo_q <= side_l.tx ? fwdp_q[PWR_DLY-1] : '0;
      revo_q <= side_l.tx ? revp_q[PWR_DLY-1] : '0;
    end
  end

  assign out_o.valid        = vld_q[NSTG-1];
  assign out_o.active       = act_q;
  assign out_o.fwd_power_mw = fwdo_q;
  assign out_o.rev_power_mw = revo_q;
  assign out_o.swr_q8       = swr_q;
  assign out_o.swr_valid    = swrv_q;

  `FRSM_ASSERT(a_ready_follows_out, in_i.ready == (!out_o.valid || out_o.ready), "request ready does not follow result side")
  `FRSM_ASSERT_IMP(a_stall_holds, !en, ##1 $stable(vld_q), "pipeline moved during a stall")
  `FRSM_ASSERT_IMP(a_swr_range, out_o.valid, (out_o.swr_q8 <= SWR_SAT) && (!out_o.swr_valid || out_o.active), "SWR result out of range or without transmit")

endmodule

// File: dv/testbench.sv
// Self-checking bench for the forward/reverse power and SWR meter.
// Depends on frsm_pkg, frsm_if and the meter RTL; drives requests, predicts every result.
module testbench;
  import frsm_pkg::*;

  typedef struct packed {
    logic            tx;
    logic [MV_W-1:0] fwd;
    logic [MV_W-1:0] rev;
  } reading_t;

  typedef struct packed {
    logic             active;
    logic [PWR_W-1:0] fwd_pwr;
    logic [PWR_W-1:0] rev_pwr;
    logic [SWR_W-1:0] swr;
    logic             swr_ok;
  } meter_t;

  typedef struct {
    reading_t rd;
    bit       drain;  // hold this request back until every result is in
  } stim_t;

  logic clk_i;
  logic rst_ni;

  frsm_in_if  req_if ();
  frsm_out_if res_if ();

  forward_reverse_power_swr_meter uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if.sink),
    .out_o (res_if.source)
  );

  stim_t  pending_q[$];
  meter_t reading_q[$];
  int     mismatches = 0;
  int     accepted_cnt = 0;
  logic   sink_hold = 1'b0;

  function automatic logic [PWR_W-1:0] mw_from_mv(logic [63:0] mv);
    logic [63:0] p;
    p = (mv * mv) / PWR_DIV;
    return (p > PWR_MAX) ? PWR_MAX : p[PWR_W-1:0];
  endfunction

  function automatic meter_t predict_meter(reading_t rd);
    meter_t      m;
    logic [63:0] f;
    logic [63:0] r;
    logic [63:0] q;
    m = '0;
    if (!rd.tx) return m;
    f = rd.fwd;
    r = rd.rev;
    m.active  = 1'b1;
    m.fwd_pwr = mw_from_mv(f);
    m.rev_pwr = mw_from_mv(r);
    if (f > SWR_MIN_FWD && r < f) begin
      m.swr_ok = 1'b1;
      // reflection ratio clamped at 49/50
      if (RHO_DEN * r > RHO_NUM * f) begin
        m.swr = SWR_SAT;
      end else begin
        q = ((f + r) << SWR_FRAC) / (f - r);
        m.swr = (q > SWR_SAT) ? SWR_SAT : q[SWR_W-1:0];
      end
    end
    return m;
  endfunction

  task automatic note_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int pick_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic void push_reading(bit tx, int f, int r, bit drain);
    stim_t s;
    s.rd.tx  = tx;
    s.rd.fwd = f[MV_W-1:0];
    s.rd.rev = r[MV_W-1:0];
    s.drain  = drain;
    pending_q.push_back(s);
  endfunction

  function automatic void push_random(bit drain);
    int kind;
    int f;
    int r;
    kind = $urandom_range(0, 9);
    f = $urandom_range(0, 4095);
    r = $urandom_range(0, 4095);
    case (kind)
      0: begin
        push_reading(1'b0, f, r, drain);
        return;
      end
      5, 6, 7: begin
        // close to total reflection
        f = $urandom_range(31, 4095);
        r = f - $urandom_range(0, f / 40 + 1);
      end
      8: begin
        // around the forward threshold
        f = $urandom_range(0, 40);
        r = $urandom_range(0, 40);
      end
      9: begin
        r = (f * $urandom_range(0, 99)) / 100;
      end
      default: ;
    endcase
    push_reading(1'b1, f, r, drain);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("forward_reverse_power_swr_meter verification failed");
    $finish;
  end

  // request driver
  int gap_left = 0;
  bit src_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        reading_q.push_back(predict_meter({req_if.tx_on, req_if.fwd_mv, req_if.rev_mv}));
        accepted_cnt++;
        gap_left = sink_hold ? 0 : pick_wait(src_calm);
      end
      if (req_if.valid && !req_if.ready) begin
        // request still waiting, keep it
      end else if (gap_left > 0) begin
        req_if.valid <= 1'b0;
        gap_left--;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain && reading_q.size() != 0)) begin
        req_if.valid     <= 1'b1;
        req_if.tx_on     <= pending_q[0].rd.tx;
        req_if.fwd_mv    <= pending_q[0].rd.fwd;
        req_if.rev_mv    <= pending_q[0].rd.rev;
        void'(pending_q.pop_front());
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // one long receiver stall partway through, so the pipe fills and back-pressures
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_hold <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (!hold_done && accepted_cnt >= 500) begin
        hold_done = 1'b1;
        hold_left = 120;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      sink_hold <= (hold_left > 0);
    end
  end

  // result monitor
  int     ready_wait = 0;
  bit     snk_calm = 1'b0;
  meter_t want_m;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      ready_wait = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (reading_q.size() == 0) begin
          note_mismatch("unexpected result", 1, 0);
        end else begin
          want_m = reading_q.pop_front();
          if (res_if.active !== want_m.active)
            note_mismatch("active", res_if.active, want_m.active);
          if (res_if.fwd_power_mw !== want_m.fwd_pwr)
            note_mismatch("fwd_power_mw", res_if.fwd_power_mw, want_m.fwd_pwr);
          if (res_if.rev_power_mw !== want_m.rev_pwr)
            note_mismatch("rev_power_mw", res_if.rev_power_mw, want_m.rev_pwr);
          if (res_if.swr_q8 !== want_m.swr)
            note_mismatch("swr_q8", res_if.swr_q8, want_m.swr);
          if (res_if.swr_valid !== want_m.swr_ok)
            note_mismatch("swr_valid", res_if.swr_valid, want_m.swr_ok);
        end
        ready_wait = pick_wait(snk_calm);
      end
      if (sink_hold) begin
        res_if.ready <= 1'b0;
      end else if (ready_wait > 0) begin
        res_if.ready <= 1'b0;
        ready_wait--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin : run
    int i;
    int cap;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.tx_on     = 1'b0;
    req_if.fwd_mv    = '0;
    req_if.rev_mv    = '0;
    res_if.ready     = 1'b0;

    // idle readings, then edges of the SWR rules and the field extremes
    push_reading(1'b0, 4095, 4095, 1'b0);
    push_reading(1'b0, 0, 0, 1'b0);
    push_reading(1'b0, 2048, 17, 1'b0);
    push_reading(1'b1, 0, 0, 1'b0);
    push_reading(1'b1, 30, 0, 1'b0);
    push_reading(1'b1, 31, 0, 1'b0);
    push_reading(1'b1, 30, 29, 1'b0);
    push_reading(1'b1, 31, 30, 1'b0);
    push_reading(1'b1, 31, 31, 1'b0);
    push_reading(1'b1, 1, 0, 1'b0);
    push_reading(1'b1, 4095, 0, 1'b0);
    push_reading(1'b1, 0, 4095, 1'b0);
    push_reading(1'b1, 4095, 4095, 1'b0);
    push_reading(1'b1, 4095, 4094, 1'b0);
    push_reading(1'b1, 50, 49, 1'b0);
    push_reading(1'b1, 100, 98, 1'b0);
    push_reading(1'b1, 100, 97, 1'b0);
    push_reading(1'b1, 4095, 4012, 1'b0);
    push_reading(1'b1, 4095, 4013, 1'b0);
    push_reading(1'b1, 1000, 500, 1'b0);
    push_reading(1'b1, 'hAAA, 'h555, 1'b0);
    push_reading(1'b1, 'h555, 'hAAA, 1'b0);
    push_reading(1'b1, 2048, 2047, 1'b0);
    push_reading(1'b1, 4095, 2048, 1'b0);

    // first random request waits for the pipe to empty; more such pauses later
    push_random(1'b1);
    for (i = 0; i < 1225; i++)
      push_random($urandom_range(0, 149) == 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || req_if.valid) @(posedge clk_i);
    cap = 0;
    while (reading_q.size() != 0 && cap < 5000) begin
      @(posedge clk_i);
      cap++;
    end
    if (reading_q.size() != 0)
      note_mismatch("results never arrived", reading_q.size(), 0);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("forward_reverse_power_swr_meter verification clean");
    end else begin
      $display("forward_reverse_power_swr_meter verification failed");
    end
    $finish;
  end

endmodule
